FILE: hdl/tsd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tsd_pkg;

    // Telnet command codes.
    localparam logic [7:0] IAC_CODE  = 8'd255;
    localparam logic [7:0] SB_CODE   = 8'd250;
    localparam logic [7:0] SE_CODE   = 8'd240;
    localparam logic [7:0] WILL_CODE = 8'd251;
    localparam logic [7:0] WONT_CODE = 8'd252;
    localparam logic [7:0] DO_CODE   = 8'd253;
    localparam logic [7:0] DONT_CODE = 8'd254;
    localparam logic [7:0] CR_CODE   = 8'd13;
    localparam logic [7:0] LF_CODE   = 8'd10;

    localparam logic [7:0] SUBNEG_OPTION_RESET = 8'd201;

    // Input transaction modes.
    localparam logic [1:0] MODE_BYTE  = 2'd0;
    localparam logic [1:0] MODE_FLUSH = 2'd1;
    localparam logic [1:0] MODE_RESET = 2'd2;

    // Result kinds.
    localparam logic [2:0] K_TEXT         = 3'd0;
    localparam logic [2:0] K_TEXT_END     = 3'd1;
    localparam logic [2:0] K_TEXT_DISCARD = 3'd2;
    localparam logic [2:0] K_PAY          = 3'd3;
    localparam logic [2:0] K_PAY_END      = 3'd4;
    localparam logic [2:0] K_PAY_DISCARD  = 3'd5;
    localparam logic [2:0] K_REPLY        = 3'd6;

    localparam int MAX_RESULTS = 3;

    typedef enum logic [2:0] {
        PH_PLAIN = 3'd0,
        PH_CMD   = 3'd1,
        PH_OPT   = 3'd2,
        PH_SBOPT = 3'd3,
        PH_BODY  = 3'd4,
        PH_SKIP  = 3'd5
    } t_phase;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] data;
        logic       negotiated_now;
        logic       last;
    } t_result;

    typedef struct packed {
        logic [1:0]                    count;
        t_result [MAX_RESULTS-1:0]     res;
    } t_bundle;

endpackage

`default_nettype wire

FILE: hdl/tsd_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Decoder state and the per-transaction decode into a bundle of up to three results.
module tsd_core
    import tsd_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_we,
    input  wire logic [7:0] i_cfg_data,
    input  wire logic       i_accept,
    input  wire logic [1:0] i_mode,
    input  wire logic [7:0] i_data_byte,
    output t_bundle         o_bundle
);

    logic [7:0] r_subneg_option;
    t_phase     r_phase,     n_phase;
    logic       r_pend_will, n_pend_will;
    logic       r_opt_en,    n_opt_en;
    logic       r_await_se,  n_await_se;
    logic       r_text_pend, n_text_pend;
    logic       r_last_cr,   n_last_cr;

    t_result [MAX_RESULTS-1:0] res;
    logic [1:0]                cnt;

    always_comb begin
        logic [7:0] b;
        logic       fwd;
        b           = i_data_byte;
        fwd         = (r_phase == PH_BODY);
        n_phase     = r_phase;
        n_pend_will = r_pend_will;
        n_opt_en    = r_opt_en;
        n_await_se  = r_await_se;
        n_text_pend = r_text_pend;
        n_last_cr   = r_last_cr;
        res         = '0;
        cnt         = 2'd0;

        case (i_mode)
            MODE_BYTE: begin
                case (r_phase)
                    PH_PLAIN: begin
                        if (b == IAC_CODE) begin
                            if (r_text_pend) begin
                                res[cnt].kind = K_TEXT_END;
                                cnt = cnt + 2'd1;
                            end
                            n_text_pend = 1'b0;
                            n_last_cr   = 1'b0;
                            n_phase     = PH_CMD;
                        end else begin
                            res[cnt].kind = K_TEXT;
                            res[cnt].data = b;
                            cnt = cnt + 2'd1;
                            n_text_pend = 1'b1;
                            if (b == LF_CODE && r_last_cr) begin
                                // CR LF closes the chunk; the chunk is open here.
                                res[cnt].kind = K_TEXT_END;
                                cnt = cnt + 2'd1;
                                n_text_pend = 1'b0;
                                n_last_cr   = 1'b0;
                            end else begin
                                n_last_cr = (b == CR_CODE);
                            end
                        end
                    end
                    PH_CMD: begin
                        if (b == IAC_CODE) begin
                            res[cnt].kind = K_TEXT;
                            res[cnt].data = IAC_CODE;
                            cnt = cnt + 2'd1;
                            n_text_pend = 1'b1;
                            n_last_cr   = 1'b0;
                            n_phase     = PH_PLAIN;
                        end else if (b == WILL_CODE || b == WONT_CODE ||
                                     b == DO_CODE || b == DONT_CODE) begin
                            n_pend_will = (b == WILL_CODE);
                            n_phase     = PH_OPT;
                        end else if (b == SB_CODE) begin
                            n_phase = PH_SBOPT;
                        end else begin
                            n_phase = PH_PLAIN;
                        end
                    end
                    PH_OPT: begin
                        if (r_pend_will && b == r_subneg_option && !r_opt_en) begin
                            res[0] = '{kind: K_REPLY, data: IAC_CODE,
                                       negotiated_now: 1'b1, last: 1'b0};
                            res[1] = '{kind: K_REPLY, data: DO_CODE,
                                       negotiated_now: 1'b1, last: 1'b0};
                            res[2] = '{kind: K_REPLY, data: r_subneg_option,
                                       negotiated_now: 1'b1, last: 1'b0};
                            cnt      = 2'd3;
                            n_opt_en = 1'b1;
                        end
                        n_phase = PH_PLAIN;
                    end
                    PH_SBOPT: begin
                        n_await_se = 1'b0;
                        n_phase    = (b == r_subneg_option) ? PH_BODY : PH_SKIP;
                    end
                    PH_BODY, PH_SKIP: begin
                        if (r_await_se) begin
                            n_await_se = 1'b0;
                            if (b == SE_CODE) begin
                                if (fwd) begin
                                    res[cnt].kind = K_PAY_END;
                                    cnt = cnt + 2'd1;
                                end
                                n_phase = PH_PLAIN;
                            end else if (fwd) begin
                                // IAC IAC gives one 0xFF; IAC x keeps both bytes.
                                res[cnt].kind = K_PAY;
                                res[cnt].data = IAC_CODE;
                                cnt = cnt + 2'd1;
                                if (b != IAC_CODE) begin
                                    res[cnt].kind = K_PAY;
                                    res[cnt].data = b;
                                    cnt = cnt + 2'd1;
                                end
                            end
                        end else if (b == IAC_CODE) begin
                            n_await_se = 1'b1;
                        end else if (fwd) begin
                            res[cnt].kind = K_PAY;
                            res[cnt].data = b;
                            cnt = cnt + 2'd1;
                        end
                    end
                    default: begin
                        n_phase = PH_PLAIN;
                    end
                endcase
            end
            MODE_FLUSH: begin
                if (r_text_pend) begin
                    res[cnt].kind = K_TEXT_END;
                    cnt = cnt + 2'd1;
                end
                n_text_pend = 1'b0;
                n_last_cr   = 1'b0;
            end
            MODE_RESET: begin
                if (r_text_pend) begin
                    res[cnt].kind = K_TEXT_DISCARD;
                    cnt = cnt + 2'd1;
                end
                if (r_phase == PH_BODY) begin
                    res[cnt].kind = K_PAY_DISCARD;
                    cnt = cnt + 2'd1;
                end
                n_phase     = PH_PLAIN;
                n_pend_will = 1'b0;
                n_opt_en    = 1'b0;
                n_await_se  = 1'b0;
                n_text_pend = 1'b0;
                n_last_cr   = 1'b0;
            end
            default: begin
                // Unused mode: no result, state kept.
            end
        endcase

        for (int i = 0; i < MAX_RESULTS; i++) begin
            res[i].last = (cnt != 2'd0) && (2'(i) == cnt - 2'd1);
        end
    end

    assign o_bundle.count = cnt;
    assign o_bundle.res   = res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_subneg_option <= SUBNEG_OPTION_RESET;
            r_phase         <= PH_PLAIN;
            r_pend_will     <= 1'b0;
            r_opt_en        <= 1'b0;
            r_await_se      <= 1'b0;
            r_text_pend     <= 1'b0;
            r_last_cr       <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_subneg_option <= i_cfg_data;
            end
            if (i_accept) begin
                r_phase     <= n_phase;
                r_pend_will <= n_pend_will;
                r_opt_en    <= n_opt_en;
                r_await_se  <= n_await_se;
                r_text_pend <= n_text_pend;
                r_last_cr   <= n_last_cr;
            end
        end
    end

endmodule

`default_nettype wire

FILE: hdl/tsd_outq.sv
`timescale 1ns / 1ps
`default_nettype none

// Holds one transaction's results and feeds them, one per cycle while the output register is free, into it.
module tsd_outq
    import tsd_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_load,
    input  wire t_bundle i_bundle,
    output logic         o_load_ready,
    output logic         o_valid,
    input  wire logic    i_ready,
    output t_result      o_result
);

    logic [1:0]                r_cnt;
    t_result [MAX_RESULTS-1:0] r_res;
    logic                      r_ovalid;
    t_result                   r_out;
    logic                      out_free;
    logic                      pop;

    assign out_free     = !r_ovalid || i_ready;
    assign pop          = out_free && (r_cnt != 2'd0);
    assign o_load_ready = (r_cnt == 2'd0) || ((r_cnt == 2'd1) && out_free);
    assign o_valid      = r_ovalid;
    assign o_result     = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt    <= 2'd0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_load) begin
                r_cnt <= i_bundle.count;
            end else if (pop) begin
                r_cnt <= r_cnt - 2'd1;
            end
            if (pop) begin
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_out <= r_res[0];
        end
        if (i_load) begin
            r_res <= i_bundle.res;
        end else if (pop) begin
            for (int i = 0; i < MAX_RESULTS - 1; i++) begin
                r_res[i] <= r_res[i+1];
            end
        end
    end

endmodule

`default_nettype wire

FILE: hdl/telnet_stream_decoder_top.sv
`timescale 1ns / 1ps
`default_nettype none

// Telnet receive-stream decoder.
// Input channel (i_valid / o_ready): one transaction per received byte (i_mode 0),
// end of read (i_mode 1, closes open text) or connection reset (i_mode 2).
// Output channel (o_valid / i_ready): zero to three result transactions per input
// transaction, in order, with o_last set on the final one that the input caused.
// Configuration channel (i_cfg_valid / o_cfg_ready): writes the subnegotiation
// option code and is always ready; the user must write it only while the block
// is idle, which the block does not enforce. Results pass through the holding
// stage and the output register. Throughput: one input transaction per cycle
// while each yields at most one result and i_ready is high; two or three results
// hold o_ready low until all but the last have entered the output register.
// While the receiver stalls, the output register holds its result and one more
// transaction's results wait in the holding stage, so o_ready stays high until
// that stage is occupied and cannot drain.
// Reset (synchronous, active low) returns the decoder to plain text, clears the
// option negotiation, empties the output path and restores option code 201.
module telnet_stream_decoder_top
    import tsd_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_ready,
    input  wire logic [1:0] i_mode,
    input  wire logic [7:0] i_data_byte,
    output logic            o_valid,
    input  wire logic       i_ready,
    output logic [2:0]      o_kind,
    output logic [7:0]      o_data,
    output logic            o_negotiated_now,
    output logic            o_last,
    input  wire logic       i_cfg_valid,
    output logic            o_cfg_ready,
    input  wire logic [7:0] i_cfg_data
);

    logic    accept;
    logic    load_ready;
    t_bundle bundle;
    t_result result;

    // The configuration register takes a write in any cycle.
    assign o_cfg_ready = 1'b1;
    assign o_ready     = load_ready;
    assign accept      = i_valid && load_ready;

    tsd_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_accept    (accept),
        .i_mode      (i_mode),
        .i_data_byte (i_data_byte),
        .o_bundle    (bundle)
    );

    // A transaction without results still loads a zero count, which leaves the
    // holding stage empty.
    tsd_outq u_outq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load       (accept),
        .i_bundle     (bundle),
        .o_load_ready (load_ready),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_result     (result)
    );

    assign o_kind           = result.kind;
    assign o_data           = result.data;
    assign o_negotiated_now = result.negotiated_now;
    assign o_last           = result.last;

endmodule

`default_nettype wire
